FILE: sv/ssl_pkg.sv
package ssl_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 12;
    localparam int ATAN_STAGES_DEF     = 14;
    localparam int TABLE_LEN           = 20;
    localparam int Q30_BITS            = 30;

    localparam int CORDIC_W = 40;
    localparam int Z_W      = 32;

    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 40'sd335544320;

    localparam logic [14:0] MAX_STEER_RESET = 15'd5325;

    localparam int CURV_KH_MAX    = 409;
    localparam int SPD_KH5_MIN    = 26;
    localparam int SPD_KH5_MAX    = 76;
    localparam int SPD_KH6_MIN    = 77;
    localparam int SPD_KH6_MAX    = 153;
    localparam int SPD_KC_ONE_MAX = 256;
    localparam int SPD_KC_TWO_MAX = 512;
    localparam int SPD_KC_THR_MAX = 768;

    localparam logic [3:0] KH10_STRAIGHT = 4'd4;
    localparam logic [3:0] KH10_SLOW     = 4'd5;
    localparam logic [3:0] KH10_MEDIUM   = 4'd6;
    localparam logic [3:0] KH10_FAST     = 4'd8;

    localparam logic [4:0] KC20_CRAWL = 5'd20;
    localparam logic [4:0] KC20_LOW   = 5'd6;
    localparam logic [4:0] KC20_MID   = 5'd4;
    localparam logic [4:0] KC20_HIGH  = 5'd3;

    localparam logic [18:0] RECIP5_M = 19'd419431;
    localparam int          RECIP5_N = 21;

    function automatic logic signed [Z_W-1:0] atan_q30(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:       v = 32'sd843314857;
            1:       v = 32'sd497837829;
            2:       v = 32'sd263043837;
            3:       v = 32'sd133525159;
            4:       v = 32'sd67021687;
            5:       v = 32'sd33543516;
            6:       v = 32'sd16775851;
            7:       v = 32'sd8388437;
            8:       v = 32'sd4194283;
            9:       v = 32'sd2097149;
            10:      v = 32'sd1048576;
            11:      v = 32'sd524288;
            12:      v = 32'sd262144;
            13:      v = 32'sd131072;
            14:      v = 32'sd65536;
            15:      v = 32'sd32768;
            16:      v = 32'sd16384;
            17:      v = 32'sd8192;
            18:      v = 32'sd4096;
            19:      v = 32'sd2048;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/ssl_cordic_cell.sv
module ssl_cordic_cell #(
    parameter int STAGE  = 0,
    parameter int HEAD_W = 38
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 adv,
    input  logic                                 valid_in,
    input  logic signed [ssl_pkg::CORDIC_W-1:0]  x_in,
    input  logic signed [ssl_pkg::CORDIC_W-1:0]  y_in,
    input  logic signed [ssl_pkg::Z_W-1:0]       z_in,
    input  logic signed [HEAD_W-1:0]             head_in,
    output logic                                 valid_out,
    output logic signed [ssl_pkg::CORDIC_W-1:0]  x_out,
    output logic signed [ssl_pkg::CORDIC_W-1:0]  y_out,
    output logic signed [ssl_pkg::Z_W-1:0]       z_out,
    output logic signed [HEAD_W-1:0]             head_out
);
    import ssl_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN_STEP = atan_q30(STAGE);

    logic                         valid_reg;
    logic signed [CORDIC_W-1:0]   x_reg, x_next;
    logic signed [CORDIC_W-1:0]   y_reg, y_next;
    logic signed [Z_W-1:0]        z_reg, z_next;
    logic signed [HEAD_W-1:0]     head_reg;
    logic signed [CORDIC_W-1:0]   dx;
    logic signed [CORDIC_W-1:0]   dy;

    always_comb begin
        dx = y_in >>> STAGE;
        dy = x_in >>> STAGE;
        if (!y_in[CORDIC_W-1]) begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN_STEP;
        end else begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN_STEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            head_reg <= head_in;
        end
    end

    assign valid_out = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign head_out  = head_reg;

endmodule

FILE: sv/ssl_front.sv
module ssl_front #(
    parameter int ANGLE_FRAC_BITS = ssl_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int HEAD_W          = 20 + ssl_pkg::Q30_BITS - ANGLE_FRAC_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 adv,
    input  logic                                 s_valid,
    input  logic signed [15:0]                   s_yaw_err,
    input  logic signed [15:0]                   s_lateral_err,
    input  logic        [15:0]                   s_speed,
    input  logic signed [15:0]                   s_path_curv,
    output logic                                 valid_out,
    output logic signed [ssl_pkg::CORDIC_W-1:0]  y_out,
    output logic signed [HEAD_W-1:0]             head_out
);
    import ssl_pkg::*;

    localparam int SH     = Q30_BITS - ANGLE_FRAC_BITS;
    localparam int PROD_W = 38;
    localparam int Q5_W   = PROD_W - RECIP5_N;

    localparam logic [HEAD_W-1:0] FRAC1 = HEAD_W'((1 * (1 << (SH - 1))) / 5);
    localparam logic [HEAD_W-1:0] FRAC2 = HEAD_W'((2 * (1 << (SH - 1))) / 5);
    localparam logic [HEAD_W-1:0] FRAC3 = HEAD_W'((3 * (1 << (SH - 1))) / 5);
    localparam logic [HEAD_W-1:0] FRAC4 = HEAD_W'((4 * (1 << (SH - 1))) / 5);

    logic [3:0]          kh10;
    logic [4:0]          kc20;
    logic signed [20:0]  yaw_prod;
    logic [20:0]         yaw_abs;

    logic                valid_a_reg;
    logic signed [21:0]  lat_a_reg, lat_a_next;
    logic [18:0]         mag_a_reg;
    logic                neg_a_reg;

    logic                valid_b_reg;
    logic signed [21:0]  lat_b_reg;
    logic [18:0]         mag_b_reg;
    logic                neg_b_reg;
    logic [PROD_W-1:0]   prod_b_reg, prod_b_next;

    logic                valid_c_reg;
    logic signed [CORDIC_W-1:0] y_c_reg, y_c_next;
    logic signed [HEAD_W-1:0]   head_c_reg, head_c_next;

    logic [Q5_W-1:0]     quot5;
    logic [18:0]         rem_full;
    logic [HEAD_W-1:0]   frac;
    logic [HEAD_W-1:0]   head_mag;

    always_comb begin
        if (s_path_curv <= CURV_KH_MAX) begin
            kh10 = KH10_STRAIGHT;
        end else if (s_speed inside {[SPD_KH5_MIN:SPD_KH5_MAX]}) begin
            kh10 = KH10_SLOW;
        end else if (s_speed inside {[SPD_KH6_MIN:SPD_KH6_MAX]}) begin
            kh10 = KH10_MEDIUM;
        end else begin
            kh10 = KH10_FAST;
        end

        if (s_speed <= SPD_KC_ONE_MAX) begin
            kc20 = KC20_CRAWL;
        end else if (s_speed <= SPD_KC_TWO_MAX) begin
            kc20 = KC20_LOW;
        end else if (s_speed <= SPD_KC_THR_MAX) begin
            kc20 = KC20_MID;
        end else begin
            kc20 = KC20_HIGH;
        end

        yaw_prod   = $signed({1'b0, kh10}) * s_yaw_err;
        yaw_abs    = yaw_prod[20] ? 21'(-yaw_prod) : 21'(yaw_prod);
        lat_a_next = $signed({1'b0, kc20}) * s_lateral_err;
    end

    assign prod_b_next = PROD_W'(mag_a_reg) * PROD_W'(RECIP5_M);

    always_comb begin
        quot5    = prod_b_reg[PROD_W-1:RECIP5_N];
        rem_full = mag_b_reg - 19'({quot5, 2'b00} + {2'b00, quot5});
        case (rem_full[2:0])
            3'd1:    frac = FRAC1;
            3'd2:    frac = FRAC2;
            3'd3:    frac = FRAC3;
            3'd4:    frac = FRAC4;
            default: frac = '0;
        endcase
        head_mag    = (HEAD_W'(quot5) << (SH - 1)) + frac;
        head_c_next = neg_b_reg ? $signed(head_mag) : -$signed(head_mag);
        y_c_next    = {{(CORDIC_W - 38){lat_b_reg[21]}}, lat_b_reg, 16'd0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end else if (adv) begin
            valid_a_reg <= s_valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lat_a_reg  <= lat_a_next;
            mag_a_reg  <= yaw_abs[18:0];
            neg_a_reg  <= s_yaw_err[15];
            lat_b_reg  <= lat_a_reg;
            mag_b_reg  <= mag_a_reg;
            neg_b_reg  <= neg_a_reg;
            prod_b_reg <= prod_b_next;
            y_c_reg    <= y_c_next;
            head_c_reg <= head_c_next;
        end
    end

    assign valid_out = valid_c_reg;
    assign y_out     = y_c_reg;
    assign head_out  = head_c_reg;

endmodule

FILE: sv/stanley_steering_law_core.sv
// Stanley lateral steering law: from heading error, cross-track error, speed and
// path curvature the core computes -kh*yaw_err - atan(kc*lateral_err), with the
// gains chosen by speed and curvature, and saturates it to +/- max_steer. The
// core is a single stalling pipeline that accepts one transaction per clock
// cycle while its result is not stalled; gain selection and heading term sit in
// front stages, each arctangent rotation cell is a register stage, and rounding
// with the limit is registered last. A stalled result holds the whole pipeline.
module stanley_steering_law_core #(
    parameter int ANGLE_FRAC_BITS = ssl_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int ATAN_STAGES     = ssl_pkg::ATAN_STAGES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [14:0]         cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [15:0]  s_yaw_err,
    input  logic signed [15:0]  s_lateral_err,
    input  logic        [15:0]  s_speed,
    input  logic signed [15:0]  s_path_curv,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [15:0]  m_steer_angle
);
    import ssl_pkg::*;

    localparam int NSTG   = (ATAN_STAGES > TABLE_LEN) ? TABLE_LEN : ATAN_STAGES;
    localparam int SH     = Q30_BITS - ANGLE_FRAC_BITS;
    localparam int HEAD_W = 20 + SH;
    localparam int TOT_W  = HEAD_W + 4;
    localparam int RES_W  = TOT_W - SH;

    logic                         adv;
    logic [14:0]                  max_steer_reg;
    logic [NSTG:0]                cell_valid;
    logic signed [CORDIC_W-1:0]   cell_x    [NSTG+1];
    logic signed [CORDIC_W-1:0]   cell_y    [NSTG+1];
    logic signed [Z_W-1:0]        cell_z    [NSTG+1];
    logic signed [HEAD_W-1:0]     cell_head [NSTG+1];

    logic signed [TOT_W-1:0]      total;
    logic signed [TOT_W-1:0]      rounded;
    logic signed [RES_W-1:0]      res;
    logic signed [RES_W-1:0]      lim_pos;
    logic signed [RES_W-1:0]      lim_neg;
    logic signed [RES_W-1:0]      clamped;

    logic                         m_valid_reg, m_valid_next;
    logic signed [15:0]           steer_reg, steer_next;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_steer_reg <= MAX_STEER_RESET;
        end else if (cfg_wr_en) begin
            max_steer_reg <= cfg_wr_data;
        end
    end

    ssl_front #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .HEAD_W          (HEAD_W)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .adv           (adv),
        .s_valid       (s_valid),
        .s_yaw_err     (s_yaw_err),
        .s_lateral_err (s_lateral_err),
        .s_speed       (s_speed),
        .s_path_curv   (s_path_curv),
        .valid_out     (cell_valid[0]),
        .y_out         (cell_y[0]),
        .head_out      (cell_head[0])
    );

    assign cell_x[0] = CORDIC_X0;
    assign cell_z[0] = '0;

    for (genvar i = 0; i < NSTG; i++) begin : g_cell
        ssl_cordic_cell #(
            .STAGE  (i),
            .HEAD_W (HEAD_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .valid_in  (cell_valid[i]),
            .x_in      (cell_x[i]),
            .y_in      (cell_y[i]),
            .z_in      (cell_z[i]),
            .head_in   (cell_head[i]),
            .valid_out (cell_valid[i+1]),
            .x_out     (cell_x[i+1]),
            .y_out     (cell_y[i+1]),
            .z_out     (cell_z[i+1]),
            .head_out  (cell_head[i+1])
        );
    end

    always_comb begin
        total   = {{(TOT_W - HEAD_W){cell_head[NSTG][HEAD_W-1]}}, cell_head[NSTG]}
                - {{(TOT_W - Z_W){cell_z[NSTG][Z_W-1]}}, cell_z[NSTG]};
        rounded = total + (TOT_W'(1) <<< (SH - 1));
        res     = RES_W'(rounded >>> SH);
        lim_pos = $signed({{(RES_W - 15){1'b0}}, max_steer_reg});
        lim_neg = -lim_pos;
        if (res > lim_pos) begin
            clamped = lim_pos;
        end else if (res < lim_neg) begin
            clamped = lim_neg;
        end else begin
            clamped = res;
        end
        steer_next   = clamped[15:0];
        m_valid_next = cell_valid[NSTG];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            steer_reg <= steer_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_steer_angle = steer_reg;

`ifndef SYNTHESIS
    a_never_most_negative: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_steer_angle != 16'sh8000))
        else $error("steering command reached the most negative code");

    a_reset_empties: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid directly after reset");

    a_stall_freezes_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |=> $stable(cell_valid))
        else $error("pipeline moved while the result was stalled");

    a_front_accepts_on_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !$past(m_valid_reg && !m_ready))
        else $error("transaction taken while the result register was stalled");
`endif

endmodule

FILE: tb/sv/stanley_steer_checker.sv
`timescale 1ns / 1ps

module stanley_steer_checker #(
    parameter int ANGLE_FRAC_BITS = ssl_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int ATAN_STAGES     = ssl_pkg::ATAN_STAGES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [14:0]        cfg_wr_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [15:0] s_yaw_err,
    input  logic signed [15:0] s_lateral_err,
    input  logic        [15:0] s_speed,
    input  logic signed [15:0] s_path_curv,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [15:0] m_steer_angle,
    output int                 steer_pending,
    output int                 mismatch_count
);

    localparam longint CURV_ONE  = 4096;
    localparam longint SPEED_ONE = 256;

    logic signed [15:0] steer_expected_q[$];
    logic signed [15:0] steer_expected;
    logic        [14:0] steer_limit;
    int                 mismatches = 0;

    function automatic logic signed [15:0] predict_steer(
        input logic signed [15:0] yaw,
        input logic signed [15:0] cte,
        input logic        [15:0] spd,
        input logic signed [15:0] curv,
        input logic        [14:0] limit
    );
        longint yaw_l, cte_l, spd_l, curv_l;
        longint kh10, kc20, x, y, z, dx, dy, step, heading, total, res, lim;
        int     shift, rotations, i;
        yaw_l  = yaw;
        cte_l  = cte;
        spd_l  = spd;
        curv_l = curv;
        shift  = ssl_pkg::Q30_BITS - ANGLE_FRAC_BITS;

        if (curv_l * 10 <= CURV_ONE) begin
            kh10 = ssl_pkg::KH10_STRAIGHT;
        end else if (spd_l * 10 > SPEED_ONE && spd_l * 10 <= 3 * SPEED_ONE) begin
            kh10 = ssl_pkg::KH10_SLOW;
        end else if (spd_l * 10 > 3 * SPEED_ONE && spd_l * 10 <= 6 * SPEED_ONE) begin
            kh10 = ssl_pkg::KH10_MEDIUM;
        end else begin
            kh10 = ssl_pkg::KH10_FAST;
        end

        if (spd_l <= SPEED_ONE) begin
            kc20 = ssl_pkg::KC20_CRAWL;
        end else if (spd_l <= 2 * SPEED_ONE) begin
            kc20 = ssl_pkg::KC20_LOW;
        end else if (spd_l <= 3 * SPEED_ONE) begin
            kc20 = ssl_pkg::KC20_MID;
        end else begin
            kc20 = ssl_pkg::KC20_HIGH;
        end

        // Vectoring rotation towards y = 0; the angle builds up in Q30.
        x = 20 * SPEED_ONE * 65536;
        y = kc20 * cte_l * 65536;
        z = 0;
        rotations = (ATAN_STAGES > ssl_pkg::TABLE_LEN) ? ssl_pkg::TABLE_LEN : ATAN_STAGES;
        for (i = 0; i < rotations; i++) begin
            step = longint'($atan(2.0 ** (-i)) * (2.0 ** ssl_pkg::Q30_BITS));
            dx   = y >>> i;
            dy   = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + step;
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - step;
            end
        end

        heading = -(kh10 * yaw_l * (longint'(1) << shift)) / 10;
        total   = heading - z;
        res     = (total + (longint'(1) << (shift - 1))) >>> shift;
        lim     = limit;
        if (res > lim) begin
            res = lim;
        end
        if (res < -lim) begin
            res = -lim;
        end
        return res[15:0];
    endfunction

    task automatic report_mismatch(input string what, input logic signed [15:0] got,
                                   input logic signed [15:0] want);
        $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            steer_expected_q.delete();
            steer_limit = ssl_pkg::MAX_STEER_RESET;
        end else begin
            if (m_valid && m_ready) begin
                if (steer_expected_q.size() == 0) begin
                    report_mismatch("steering result with no transaction outstanding",
                                    m_steer_angle, 16'sd0);
                end else begin
                    steer_expected = steer_expected_q.pop_front();
                    if (m_steer_angle !== steer_expected) begin
                        report_mismatch("steer_angle mismatch", m_steer_angle, steer_expected);
                    end
                end
            end
            if (s_valid && s_ready) begin
                steer_expected_q.push_back(predict_steer(s_yaw_err, s_lateral_err, s_speed,
                                                         s_path_curv, steer_limit));
            end
            if (cfg_wr_en) begin
                steer_limit = cfg_wr_data;
            end
        end
        steer_pending  <= steer_expected_q.size();
        mismatch_count <= mismatches;
    end

endmodule

FILE: tb/sv/tb_stanley_steering_law_core.sv
`timescale 1ns / 1ps

module tb_stanley_steering_law_core;

    localparam int DRAIN_CYCLES = ssl_pkg::ATAN_STAGES_DEF + 12;
    localparam int HOLD_CYCLES  = 400;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [14:0]        cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_yaw_err;
    logic signed [15:0] s_lateral_err;
    logic        [15:0] s_speed;
    logic signed [15:0] s_path_curv;
    logic               m_valid;
    logic               m_ready;
    logic signed [15:0] m_steer_angle;

    int steer_pending;
    int mismatch_count;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_requests = 0;

    stanley_steering_law_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_yaw_err     (s_yaw_err),
        .s_lateral_err (s_lateral_err),
        .s_speed       (s_speed),
        .s_path_curv   (s_path_curv),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_steer_angle (m_steer_angle)
    );

    stanley_steer_checker steer_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_yaw_err      (s_yaw_err),
        .s_lateral_err  (s_lateral_err),
        .s_speed        (s_speed),
        .s_path_curv    (s_path_curv),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_steer_angle  (m_steer_angle),
        .steer_pending  (steer_pending),
        .mismatch_count (mismatch_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // The receiver; a requested hold-off keeps m_ready low so that the pipeline fills up.
    initial begin
        int holds_served;
        holds_served = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (holds_served != hold_requests) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holds_served++;
            end else begin
                m_ready <= aresetn && ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic offer_sample(input logic signed [15:0] yaw, input logic signed [15:0] cte,
                                input logic [15:0] spd, input logic signed [15:0] curv);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_yaw_err     <= yaw;
        s_lateral_err <= cte;
        s_speed       <= spd;
        s_path_curv   <= curv;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic offer_random();
        logic signed [15:0] yaw, cte, curv;
        logic        [15:0] spd, edge_spd;
        if ($urandom_range(1) == 1) begin
            yaw = 16'($urandom);
        end else begin
            yaw = 16'($urandom_range(4096) - 2048);
        end
        if ($urandom_range(1) == 1) begin
            cte = 16'($urandom);
        end else begin
            cte = 16'($urandom_range(1200) - 600);
        end
        if ($urandom_range(1) == 1) begin
            curv = 16'($urandom);
        end else begin
            curv = 16'($urandom_range(520, 300));
        end
        case ($urandom_range(6))
            0:       edge_spd = 16'(ssl_pkg::SPD_KH5_MIN);
            1:       edge_spd = 16'(ssl_pkg::SPD_KH5_MAX);
            2:       edge_spd = 16'(ssl_pkg::SPD_KH6_MAX);
            3:       edge_spd = 16'(ssl_pkg::SPD_KC_ONE_MAX);
            4:       edge_spd = 16'(ssl_pkg::SPD_KC_TWO_MAX);
            default: edge_spd = 16'(ssl_pkg::SPD_KC_THR_MAX);
        endcase
        case ($urandom_range(3))
            0:       spd = 16'($urandom);
            3:       spd = 16'(edge_spd + $urandom_range(2) - 1);
            default: spd = 16'($urandom_range(1000));
        endcase
        offer_sample(yaw, cte, spd, curv);
    endtask

    task automatic run_random(input int count, input int tx_pct, input int rx_pct,
                              input bit with_hold);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        if (with_hold) begin
            hold_requests++;
        end
        repeat (count) offer_random();
        s_valid <= 1'b0;
    endtask

    task automatic write_max_steer(input logic [14:0] limit);
        @(posedge aclk);
        while (steer_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_valid       <= 1'b0;
        s_yaw_err     <= '0;
        s_lateral_err <= '0;
        s_speed       <= '0;
        s_path_curv   <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Corner cases with the limit wide open, so that the raw law is visible.
        write_max_steer(15'h7FFF);
        tx_idle_pct = 31;
        rx_idle_pct = 83;
        offer_sample(16'sd0, 16'sd0, 16'd0, 16'sd0);
        offer_sample(16'sh7FFF, 16'sh7FFF, 16'd0, 16'sd0);
        offer_sample(16'sh8000, 16'sh8000, 16'hFFFF, 16'sh7FFF);
        offer_sample(16'sh8000, 16'sh7FFF, 16'hFFFF, 16'sh7FFF);
        offer_sample(16'sh7FFF, 16'sh8000, 16'd80, 16'sh7FFF);
        offer_sample(16'sd1000, 16'sd256, 16'd25, 16'sd410);
        offer_sample(16'sd1000, 16'sd256, 16'd26, 16'sd410);
        offer_sample(16'sd1000, -16'sd256, 16'd76, 16'sd410);
        offer_sample(16'sd1000, -16'sd256, 16'd77, 16'sd410);
        offer_sample(-16'sd1000, 16'sd512, 16'd153, 16'sd410);
        offer_sample(-16'sd1000, 16'sd512, 16'd154, 16'sd410);
        offer_sample(16'sd500, 16'sd100, 16'd100, 16'sd409);
        offer_sample(16'sd500, 16'sd100, 16'd100, 16'sh8000);
        offer_sample(16'sd500, 16'sd1000, 16'd256, 16'sd4096);
        offer_sample(16'sd500, 16'sd1000, 16'd257, 16'sd4096);
        offer_sample(16'sd500, -16'sd1000, 16'd512, 16'sd4096);
        offer_sample(16'sd500, -16'sd1000, 16'd513, 16'sd4096);
        offer_sample(-16'sd500, 16'sd3000, 16'd768, -16'sd4096);
        offer_sample(-16'sd500, 16'sd3000, 16'd769, -16'sd4096);
        offer_sample(16'sd0, 16'sd0, 16'd1000, 16'sd5000);
        offer_sample(16'sd0, 16'sd1, 16'd0, 16'sd0);
        offer_sample(16'sd0, -16'sd1, 16'd0, 16'sd0);
        offer_sample(16'sd1, 16'sd0, 16'd300, 16'sd0);
        offer_sample(-16'sd1, 16'sd0, 16'd300, 16'sd0);
        s_valid <= 1'b0;

        write_max_steer(ssl_pkg::MAX_STEER_RESET);
        run_random(400, 31, 83, 1'b0);
        write_max_steer(15'h7FFF);
        run_random(400, 83, 31, 1'b1);
        write_max_steer(15'd0);
        run_random(40, 0, 0, 1'b0);
        write_max_steer(15'd1500);
        run_random(360, 0, 0, 1'b1);

        @(posedge aclk);
        while (steer_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && steer_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
